// File: rtl/chm_pkg.sv
package chm_pkg;

    localparam logic [1:0] OP_PUT    = 2'd0;
    localparam logic [1:0] OP_GET    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam logic [31:0] MIX_MUL = 32'h045d9f3b;

    // One multiply-xorshift round of the key mixing hash, modulo 2^32.
    function automatic logic [31:0] mix_round(input logic [31:0] x);
        return (x ^ (x >> 16)) * MIX_MUL;
    endfunction

endpackage

// File: rtl/chm_ram.sv
module chm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/chained_hash_map_top.sv
// Chained hash map: key-value store for 32-bit keys with separate chaining.
// Input channel (in_valid/in_ready) carries op (put, get, remove), key and
// value. Output channel (out_valid/out_ready) returns one item per input:
// found, read_value, status (1 = put refused, node pool full) and the
// number of stored keys after the operation.
// Work per item: the first hash multiply is done as the item is accepted,
// then the second multiply, the bucket reduction (a reciprocal quotient,
// a remainder and a correcting subtract unless BUCKETS is a power of two),
// the head memory read, one node read per chain node visited, update and
// write-back, and the load of the output register. The unused op goes
// straight to the output register. One item is in work at a time; in_ready
// rises as the result moves into the output register.
// After reset a clearing pass over max(BUCKETS, NODES) addresses empties the
// bucket heads and refills the free stack; in_ready stays low meanwhile.
// When the receiver stalls, the result holds in the output register and a
// following item finishes its work and waits until that register is free.
module chained_hash_map_top #(
    parameter int BUCKETS = 128,
    parameter int NODES   = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [31:0] key,
    input  logic [31:0] value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        found,
    output logic [31:0] read_value,
    output logic        status,
    output logic [8:0]  entry_count
);
    import chm_pkg::*;

    localparam int  BW   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int  NW   = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int  CW   = $clog2(NODES + 1);
    localparam int  HW   = NW + 1;
    localparam int  NEW  = 65 + NW;
    localparam int  MAXD = (BUCKETS > NODES) ? BUCKETS : NODES;
    localparam int  IW   = $clog2(MAXD);
    localparam bit  POW2 = (BUCKETS & (BUCKETS - 1)) == 0;
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / BUCKETS);

    localparam logic [3:0] S_INIT = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_MIX2 = 4'd2;
    localparam logic [3:0] S_MOD  = 4'd3;
    localparam logic [3:0] S_HREQ = 4'd4;
    localparam logic [3:0] S_HEAD = 4'd5;
    localparam logic [3:0] S_NODE = 4'd6;
    localparam logic [3:0] S_ACT  = 4'd7;
    localparam logic [3:0] S_POP  = 4'd8;
    localparam logic [3:0] S_LINK = 4'd9;
    localparam logic [3:0] S_RESP = 4'd10;

    logic [3:0]    state_reg, state_next;
    logic [IW-1:0] init_reg, init_next;
    logic [1:0]    op_reg, op_next;
    logic [31:0]   key_reg, key_next;
    logic [31:0]   val_reg, val_next;
    logic [31:0]   x_reg, x_next;
    logic [1:0]    phase_reg, phase_next;
    logic [31:0]   div_reg, div_next;
    logic [BW-1:0] bkt_reg, bkt_next;
    logic [NW-1:0] cur_reg, cur_next;
    logic [NW-1:0] prev_reg, prev_next;
    logic          has_prev_reg, has_prev_next;
    logic [NEW-1:0] cur_ent_reg, cur_ent_next;
    logic [NEW-1:0] prev_ent_reg, prev_ent_next;
    logic          hit_reg, hit_next;
    logic [31:0]   rd_reg, rd_next;
    logic          st_reg, st_next;
    logic [CW-1:0] free_cnt_reg, free_cnt_next;
    logic [CW-1:0] stored_reg, stored_next;
    logic          out_valid_reg, out_valid_next;
    logic          found_reg, found_next;
    logic [31:0]   out_rd_reg, out_rd_next;
    logic          out_st_reg, out_st_next;
    logic [8:0]    out_cnt_reg, out_cnt_next;

    logic          head_we;
    logic [BW-1:0] head_waddr, head_raddr;
    logic [HW-1:0] head_wdata, head_rdata;
    logic          node_we;
    logic [NW-1:0] node_waddr, node_raddr;
    logic [NEW-1:0] node_wdata, node_rdata;
    logic          free_we;
    logic [NW-1:0] free_waddr, free_raddr;
    logic [NW-1:0] free_wdata, free_rdata;

    logic [31:0]   hash;
    logic [63:0]   recip_prod;
    logic [31:0]   nd_key;
    logic          nd_lv;
    logic [NW-1:0] nd_li;

    chm_ram #(.WIDTH(HW), .DEPTH(BUCKETS)) u_heads (
        .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
        .raddr(head_raddr), .rdata(head_rdata)
    );

    chm_ram #(.WIDTH(NEW), .DEPTH(NODES)) u_nodes (
        .clk(clk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
        .raddr(node_raddr), .rdata(node_rdata)
    );

    chm_ram #(.WIDTH(NW), .DEPTH(NODES)) u_free (
        .clk(clk), .we(free_we), .waddr(free_waddr), .wdata(free_wdata),
        .raddr(free_raddr), .rdata(free_rdata)
    );

    assign hash       = x_reg ^ (x_reg >> 16);
    assign recip_prod = {32'd0, hash} * {32'd0, RECIP};
    assign nd_key     = node_rdata[NEW-1 -: 32];
    assign nd_lv      = node_rdata[NW];
    assign nd_li      = node_rdata[NW-1:0];

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign read_value  = out_rd_reg;
    assign status      = out_st_reg;
    assign entry_count = out_cnt_reg;

    always_comb
    begin
        state_next     = state_reg;
        init_next      = init_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        val_next       = val_reg;
        x_next         = x_reg;
        phase_next     = phase_reg;
        div_next       = div_reg;
        bkt_next       = bkt_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        has_prev_next  = has_prev_reg;
        cur_ent_next   = cur_ent_reg;
        prev_ent_next  = prev_ent_reg;
        hit_next       = hit_reg;
        rd_next        = rd_reg;
        st_next        = st_reg;
        free_cnt_next  = free_cnt_reg;
        stored_next    = stored_reg;
        out_valid_next = out_valid_reg;
        found_next     = found_reg;
        out_rd_next    = out_rd_reg;
        out_st_next    = out_st_reg;
        out_cnt_next   = out_cnt_reg;
        head_we        = 1'b0;
        head_waddr     = bkt_reg;
        head_wdata     = '0;
        head_raddr     = bkt_reg;
        node_we        = 1'b0;
        node_waddr     = cur_reg;
        node_wdata     = '0;
        node_raddr     = cur_reg;
        free_we        = 1'b0;
        free_waddr     = NW'(free_cnt_reg);
        free_wdata     = cur_reg;
        free_raddr     = NW'(free_cnt_reg - CW'(1));

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_INIT:
            begin
                if (32'(init_reg) < BUCKETS)
                begin
                    head_we    = 1'b1;
                    head_waddr = BW'(init_reg);
                end
                if (32'(init_reg) < NODES)
                begin
                    free_we    = 1'b1;
                    free_waddr = NW'(init_reg);
                    free_wdata = NW'(init_reg);
                end
                init_next = init_reg + IW'(1);
                if (32'(init_reg) == MAXD - 1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next       = op;
                    key_next      = key;
                    val_next      = value;
                    x_next        = mix_round(key);
                    hit_next      = 1'b0;
                    rd_next       = '0;
                    st_next       = 1'b0;
                    has_prev_next = 1'b0;
                    state_next    = (op == OP_PUT || op == OP_GET || op == OP_REMOVE)
                                    ? S_MIX2 : S_RESP;
                end
            end
            S_MIX2:
            begin
                x_next     = mix_round(x_reg);
                phase_next = 2'd0;
                state_next = S_MOD;
            end
            S_MOD:
            begin
                if (POW2)
                begin
                    bkt_next   = hash[BW-1:0];
                    state_next = S_HREQ;
                end
                else
                begin
                    // The reciprocal estimate of the quotient is at most one low,
                    // so a single compare and subtract completes the remainder.
                    if (phase_reg == 2'd0)
                    begin
                        div_next   = recip_prod[63:32];
                        phase_next = 2'd1;
                    end
                    else if (phase_reg == 2'd1)
                    begin
                        div_next   = hash - div_reg * 32'(BUCKETS);
                        phase_next = 2'd2;
                    end
                    else
                    begin
                        bkt_next   = (div_reg >= 32'(BUCKETS))
                                     ? BW'(div_reg - 32'(BUCKETS)) : BW'(div_reg);
                        state_next = S_HREQ;
                    end
                end
            end
            S_HREQ:
            begin
                state_next = S_HEAD;
            end
            S_HEAD:
            begin
                if (head_rdata[NW])
                begin
                    cur_next   = head_rdata[NW-1:0];
                    node_raddr = head_rdata[NW-1:0];
                    state_next = S_NODE;
                end
                else
                begin
                    state_next = S_ACT;
                end
            end
            S_NODE:
            begin
                if (nd_key == key_reg)
                begin
                    hit_next     = 1'b1;
                    cur_ent_next = node_rdata;
                    state_next   = S_ACT;
                end
                else
                begin
                    prev_next     = cur_reg;
                    prev_ent_next = node_rdata;
                    has_prev_next = 1'b1;
                    if (nd_lv)
                    begin
                        cur_next   = nd_li;
                        node_raddr = nd_li;
                    end
                    else
                    begin
                        state_next = S_ACT;
                    end
                end
            end
            S_ACT:
            begin
                state_next = S_RESP;
                case (op_reg)
                    OP_PUT:
                    begin
                        if (hit_reg)
                        begin
                            node_we    = 1'b1;
                            node_wdata = {key_reg, val_reg, cur_ent_reg[NW:0]};
                        end
                        else if (free_cnt_reg == '0)
                        begin
                            st_next = 1'b1;
                        end
                        else
                        begin
                            state_next = S_POP;
                        end
                    end
                    OP_GET:
                    begin
                        if (hit_reg)
                        begin
                            rd_next = cur_ent_reg[NW+32 -: 32];
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (hit_reg)
                        begin
                            if (has_prev_reg)
                            begin
                                node_we    = 1'b1;
                                node_waddr = prev_reg;
                                node_wdata = {prev_ent_reg[NEW-1:NW+1], cur_ent_reg[NW:0]};
                            end
                            else
                            begin
                                head_we    = 1'b1;
                                head_wdata = cur_ent_reg[NW:0];
                            end
                            if (32'(free_cnt_reg) < NODES)
                            begin
                                free_we       = 1'b1;
                                free_cnt_next = free_cnt_reg + CW'(1);
                            end
                            if (stored_reg != '0)
                            begin
                                stored_next = stored_reg - CW'(1);
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_POP:
            begin
                cur_next      = free_rdata;
                node_we       = 1'b1;
                node_waddr    = free_rdata;
                node_wdata    = {key_reg, val_reg, 1'b0, NW'(0)};
                free_cnt_next = free_cnt_reg - CW'(1);
                stored_next   = stored_reg + CW'(1);
                if (has_prev_reg)
                begin
                    state_next = S_LINK;
                end
                else
                begin
                    head_we    = 1'b1;
                    head_wdata = {1'b1, free_rdata};
                    state_next = S_RESP;
                end
            end
            S_LINK:
            begin
                node_we    = 1'b1;
                node_waddr = prev_reg;
                node_wdata = {prev_ent_reg[NEW-1:NW+1], 1'b1, cur_reg};
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    found_next     = hit_reg;
                    out_rd_next    = rd_reg;
                    out_st_next    = st_reg;
                    out_cnt_next   = 9'(stored_reg);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            init_reg      <= '0;
            free_cnt_reg  <= CW'(NODES);
            stored_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_reg      <= init_next;
            free_cnt_reg  <= free_cnt_next;
            stored_reg    <= stored_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        key_reg      <= key_next;
        val_reg      <= val_next;
        x_reg        <= x_next;
        phase_reg    <= phase_next;
        div_reg      <= div_next;
        bkt_reg      <= bkt_next;
        cur_reg      <= cur_next;
        prev_reg     <= prev_next;
        has_prev_reg <= has_prev_next;
        cur_ent_reg  <= cur_ent_next;
        prev_ent_reg <= prev_ent_next;
        hit_reg      <= hit_next;
        rd_reg       <= rd_next;
        st_reg       <= st_next;
        found_reg    <= found_next;
        out_rd_reg   <= out_rd_next;
        out_st_reg   <= out_st_next;
        out_cnt_reg  <= out_cnt_next;
    end

`ifndef SYNTH
    a_pool_balance: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> 32'(free_cnt_reg) + 32'(stored_reg) == NODES)
        else $error("free and stored node counts do not add up to the pool size");

    a_refuse_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESP && st_reg) |-> free_cnt_reg == '0)
        else $error("put refused while free nodes remain");

    a_refuse_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESP && st_reg) |-> !hit_reg)
        else $error("put refused for a key that is already stored");
`endif

endmodule

// File: tb/tb_hash_map_checker.sv
`timescale 1ns / 100ps

module tb_hash_map_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  op,
    input  logic [31:0] key,
    input  logic [31:0] value,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        found,
    input  logic [31:0] read_value,
    input  logic        status,
    input  logic [8:0]  entry_count,
    output int          error_count,
    output int          pending_count
);
    import chm_pkg::*;

    localparam int BUCKET_CNT = 128;
    localparam int NODE_CNT   = 256;

    typedef struct packed {
        logic        found;
        logic [31:0] read_value;
        logic        status;
        logic [8:0]  entry_count;
    } map_reply_t;

    // Shadow of the table: per-bucket chains, oldest node first.
    logic [31:0] chain_keys[BUCKET_CNT][$];
    logic [31:0] chain_vals[BUCKET_CNT][$];
    int          stored_keys;
    map_reply_t  expected_replies[$];

    function automatic logic [31:0] key_bucket(input logic [31:0] k);
        logic [31:0] x;
        logic [63:0] p;
        x = k;
        repeat (2)
        begin
            p = {32'd0, x ^ (x >> 16)} * 64'h045d9f3b;
            x = p[31:0];
        end
        x = x ^ (x >> 16);
        return x % BUCKET_CNT;
    endfunction

    function automatic map_reply_t apply_op(input logic [1:0] o, input logic [31:0] k,
                                            input logic [31:0] v);
        map_reply_t r;
        int b;
        int hit;
        r = '0;
        b = key_bucket(k);
        hit = -1;
        if (o != OP_NONE)
            for (int i = 0; i < chain_keys[b].size(); i++)
                if (hit < 0 && chain_keys[b][i] == k)
                    hit = i;
        r.found = (hit >= 0);
        if (o == OP_PUT)
        begin
            if (hit >= 0)
                chain_vals[b][hit] = v;
            else if (stored_keys == NODE_CNT)
                r.status = 1'b1;
            else
            begin
                chain_keys[b].push_back(k);
                chain_vals[b].push_back(v);
                stored_keys++;
            end
        end
        else if (o == OP_GET && hit >= 0)
            r.read_value = chain_vals[b][hit];
        else if (o == OP_REMOVE && hit >= 0)
        begin
            chain_keys[b].delete(hit);
            chain_vals[b].delete(hit);
            stored_keys--;
        end
        r.entry_count = stored_keys[8:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        error_count++;
    endtask

    assign pending_count = expected_replies.size();

    initial
    begin
        error_count = 0;
        stored_keys = 0;
    end

    always @(posedge clk)
    begin
        map_reply_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_replies.size() == 0)
            begin
                $display("%0t: unexpected result item", $realtime);
                error_count++;
            end
            else
            begin
                want = expected_replies.pop_front();
                if (found !== want.found)
                    report_mismatch("found", 32'(found), 32'(want.found));
                if (read_value !== want.read_value)
                    report_mismatch("read_value", read_value, want.read_value);
                if (status !== want.status)
                    report_mismatch("status", 32'(status), 32'(want.status));
                if (entry_count !== want.entry_count)
                    report_mismatch("entry_count", 32'(entry_count),
                                    32'(want.entry_count));
            end
        end
        if (rst_n && in_valid && in_ready)
            expected_replies.push_back(apply_op(op, key, value));
    end
endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import chm_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  op;
    logic [31:0] key;
    logic [31:0] value;
    logic        out_valid;
    logic        out_ready;
    logic        found;
    logic [31:0] read_value;
    logic        status;
    logic [8:0]  entry_count;
    int          error_count;
    int          pending_count;
    int          cycle_count;
    bit          stim_done;
    bit          rx_steady;
    logic [31:0] key_pool[32];

    chained_hash_map_top uut (.*);

    tb_hash_map_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Returns at the falling edge after the item is accepted, with in_valid still
    // high, so a following item with no gap keeps valid asserted.
    task automatic send_op(input logic [1:0] o, input logic [31:0] k, input logic [31:0] v);
        int gap;
        gap = $urandom_range(0, 13);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        key <= k;
        value <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Receiver holds off out_ready at random before each item, with calm stretches.
    initial
    begin
        int waits;
        out_ready = 1'b0;
        rx_steady = 1'b0;
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 99) == 0)
                rx_steady = ~rx_steady;
            waits = rx_steady ? 0 : $urandom_range(0, 13);
            if (waits != 0)
            begin
                out_ready <= 1'b0;
                repeat (waits) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!(out_valid && out_ready))
                @(posedge clk);
        end
    end

    initial
    begin
        logic [31:0] k;
        int r;
        stim_done = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        op = OP_PUT;
        key = '0;
        value = '0;
        foreach (key_pool[i])
            key_pool[i] = $urandom();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: misses on an empty table, extremes, overwrite, unused op.
        send_op(OP_GET, 32'h0, 32'h0);
        send_op(OP_REMOVE, 32'hFFFF_FFFF, 32'h0);
        send_op(OP_PUT, 32'h0, 32'hFFFF_FFFF);
        send_op(OP_PUT, 32'hFFFF_FFFF, 32'h0);
        send_op(OP_GET, 32'h0, 32'h1234);
        send_op(OP_PUT, 32'h0, 32'h5A5A_A5A5);
        send_op(OP_GET, 32'h0, 32'h0);
        send_op(OP_NONE, 32'h0, 32'hFFFF_FFFF);
        send_op(OP_GET, 32'hFFFF_FFFF, 32'h0);
        send_op(OP_REMOVE, 32'h0, 32'h0);
        send_op(OP_GET, 32'h0, 32'h0);
        send_op(OP_REMOVE, 32'h0, 32'h0);

        // Fill the pool past full so refused puts and full-pool overwrites occur.
        for (int i = 0; i < 262; i++)
            send_op(OP_PUT, 32'h1000_0000 + i, $urandom());
        send_op(OP_PUT, 32'h1000_0005, 32'hDEAD_BEEF);
        send_op(OP_GET, 32'h1000_0005, 32'h0);
        send_op(OP_PUT, 32'hFFFF_FFFF, 32'h1);
        // Drain it again, removing from the middle and the tails of chains.
        for (int i = 0; i < 256; i++)
            send_op(OP_REMOVE, 32'h1000_0000 + ((i * 37) % 256), 32'h0);

        // Random mix on a small key pool so chains, hits and removes recur.
        for (int i = 0; i < 320; i++)
        begin
            r = $urandom_range(0, 99);
            k = ($urandom_range(0, 9) == 0) ? $urandom() : key_pool[$urandom_range(0, 31)];
            if (r < 40)
                send_op(OP_PUT, k, $urandom());
            else if (r < 70)
                send_op(OP_GET, k, $urandom());
            else if (r < 95)
                send_op(OP_REMOVE, k, $urandom());
            else
                send_op(OP_NONE, k, $urandom());
        end
        in_valid <= 1'b0;
        stim_done = 1;
    end

    initial
    begin
        wait (stim_done);
        while (pending_count != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
